/* hdl/date_add_subtract_days_unit_macros.svh */
`ifndef DATE_ADD_SUBTRACT_DAYS_UNIT_MACROS_SVH
`define DATE_ADD_SUBTRACT_DAYS_UNIT_MACROS_SVH

// same-cycle implication on aclk, off during reset
`define DASD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on aclk, off during reset
`define DASD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/dasd_pkg.sv */
`default_nettype none

package dasd_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int COUNT_IN_BITS  = 16;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [15:0] YEAR_MAX = 16'hFFFF;
    localparam logic [15:0] YEAR_MIN = 16'h0000;

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_SUB = 1'b1;

    typedef struct packed {
        logic done;
        logic ovf;
    } step_status_t;

    // leap year every fourth year, no century rule
    function automatic logic [4:0] days_in(input logic [3:0] month, input logic [15:0] year);
        logic [4:0] n;
        case (month) inside
            MONTH_FEB: n = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

/* hdl/dasd_step.sv */
`default_nettype none

module dasd_step import dasd_pkg::*; #(
    parameter int DAY_W = COUNT_BITS_DEF + 2
) (
    input  wire logic                    kind,
    input  wire logic signed [DAY_W-1:0] day,
    input  wire logic        [3:0]       month,
    input  wire logic        [15:0]      year,
    output logic signed      [DAY_W-1:0] day_next,
    output logic             [3:0]       month_next,
    output logic             [15:0]      year_next,
    output step_status_t                 status
);

    logic        [4:0]       cur_len;
    logic        [4:0]       prev_len;
    logic        [3:0]       prev_month;
    logic        [15:0]      prev_year;
    logic                    prev_ovf;
    logic        [3:0]       succ_month;
    logic        [15:0]      succ_year;
    logic                    succ_ovf;
    logic signed [DAY_W-1:0] cur_len_s;
    logic signed [DAY_W-1:0] prev_len_s;
    logic signed [DAY_W-1:0] operand;

    always_comb begin
        succ_ovf  = 1'b0;
        succ_year = year;
        if (month == MONTH_DEC) begin
            succ_month = MONTH_JAN;
            if (year == YEAR_MAX) begin
                succ_ovf = 1'b1;
            end else begin
                succ_year = year + 16'd1;
            end
        end else begin
            succ_month = month + 4'd1;
        end
    end

    always_comb begin
        prev_ovf  = 1'b0;
        prev_year = year;
        if (month == MONTH_JAN) begin
            prev_month = MONTH_DEC;
            if (year == YEAR_MIN) begin
                prev_ovf = 1'b1;
            end else begin
                prev_year = year - 16'd1;
            end
        end else begin
            prev_month = month - 4'd1;
        end
    end

    assign cur_len    = days_in(month, year);
    assign prev_len   = days_in(prev_month, prev_year);
    assign cur_len_s  = signed'({{(DAY_W-5){1'b0}}, cur_len});
    assign prev_len_s = signed'({{(DAY_W-5){1'b0}}, prev_len});

    // shared adder: subtract this month going forward, add previous month going back
    assign operand  = (kind == KIND_SUB) ? prev_len_s : -cur_len_s;
    assign day_next = day + operand;

    always_comb begin
        if (kind == KIND_SUB) begin
            status.done = !(day[DAY_W-1] || (day == '0));
            status.ovf  = prev_ovf;
            month_next  = prev_month;
            year_next   = prev_year;
        end else begin
            status.done = !(day > cur_len_s);
            status.ovf  = succ_ovf;
            month_next  = succ_month;
            year_next   = succ_year;
        end
    end

endmodule

`default_nettype wire

/* hdl/date_add_subtract_days_unit.sv */
`default_nettype none

// Adds or subtracts a day count to a calendar date, one month per clock
// cycle through a single shared step unit. The result is valid on m_* once
// the step unit has crossed every month boundary after the input transfer,
// and the next input transfer can come at the earliest in the cycle after
// the result transfer; s_tready is low from acceptance until the result
// transfer on m_*.
// Every year divisible by four is a leap year. Out-of-range start months
// and days are clamped, and a year that would pass 0 or 65535 saturates
// with year_overflow set. Only the low COUNT_BITS bits of day_count count.

module date_add_subtract_days_unit import dasd_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // start_day[4:0], start_month[8:5], start_year[24:9], day_count[40:25]
    input  wire logic [47:0] s_tdata,
    // kind
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // result_day[4:0], result_month[8:5], result_year[24:9]
    output logic [31:0]      m_tdata,
    // year_overflow
    output logic             m_tuser
);

    localparam int DAY_W    = COUNT_BITS + 2;
    localparam int USE_BITS = (COUNT_BITS < COUNT_IN_BITS) ? COUNT_BITS : COUNT_IN_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic                    kind_reg;
    logic signed [DAY_W-1:0] day_reg;
    logic        [3:0]       month_reg;
    logic        [15:0]      year_reg;
    logic                    ovf_reg;

    logic        [4:0]       in_day;
    logic        [3:0]       in_month;
    logic        [15:0]      in_year;
    logic        [3:0]       month_c;
    logic        [4:0]       day_c;
    logic        [4:0]       start_len;
    logic        [DAY_W-1:0] count_ext;
    logic        [DAY_W-1:0] day_c_ext;
    logic signed [DAY_W-1:0] day_init;

    logic signed [DAY_W-1:0] step_day;
    logic        [3:0]       step_month;
    logic        [15:0]      step_year;
    step_status_t            step_st;

    assign in_day   = s_tdata[4:0];
    assign in_month = s_tdata[8:5];
    assign in_year  = s_tdata[24:9];

    // clamp the start date
    always_comb begin
        if (in_month < MONTH_JAN) begin
            month_c = MONTH_JAN;
        end else if (in_month > MONTH_DEC) begin
            month_c = MONTH_DEC;
        end else begin
            month_c = in_month;
        end
        start_len = days_in(month_c, in_year);
        day_c     = (in_day == 5'd0) ? 5'd1 : in_day;
        if (day_c > start_len) begin
            day_c = start_len;
        end
    end

    assign count_ext = {{(DAY_W-USE_BITS){1'b0}}, s_tdata[25 +: USE_BITS]};
    assign day_c_ext = {{(DAY_W-5){1'b0}}, day_c};
    assign day_init  = (s_tuser == KIND_SUB) ? signed'(day_c_ext - count_ext)
                                             : signed'(day_c_ext + count_ext);

    dasd_step #(
        .DAY_W(DAY_W)
    ) u_step (
        .kind      (kind_reg),
        .day       (day_reg),
        .month     (month_reg),
        .year      (year_reg),
        .day_next  (step_day),
        .month_next(step_month),
        .year_next (step_year),
        .status    (step_st)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step_st.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            kind_reg  <= s_tuser;
            day_reg   <= day_init;
            month_reg <= month_c;
            year_reg  <= in_year;
            ovf_reg   <= 1'b0;
        end else if (state_reg == ST_RUN && !step_st.done) begin
            day_reg   <= step_day;
            month_reg <= step_month;
            year_reg  <= step_year;
            ovf_reg   <= ovf_reg | step_st.ovf;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {7'd0, year_reg, month_reg, day_reg[4:0]};
    assign m_tuser  = ovf_reg;

endmodule

`default_nettype wire

/* hdl/dasd_checker.sv */
`default_nettype none

`include "date_add_subtract_days_unit_macros.svh"

module dasd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    `DASD_ASSERT_IMP(a_one_item, s_tready, !m_tvalid, "ready while a result is pending")
    `DASD_ASSERT_NXT(a_busy_after_in, s_tvalid && s_tready, !s_tready, "ready after input transfer")
    `DASD_ASSERT_NXT(a_idle_after_out, m_tvalid && m_tready, s_tready, "not ready after output transfer")
    `DASD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    `DASD_ASSERT_IMP(a_date_valid, m_tvalid, (m_tdata[4:0] != 5'd0) && (m_tdata[8:5] != 4'd0) && (m_tdata[8:5] <= 4'd12), "result date out of range")

endmodule

bind date_add_subtract_days_unit dasd_checker u_dasd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

`default_nettype wire
